// ===== sv/hcd_pkg.sv =====
// hcd_pkg: shared types, codes and the byte classifier for the chunked deframer.
// Used by hcd_front, hcd_back and http_chunked_deframer; no dependencies.

package hcd_pkg;

   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_SEMI = 8'h3B;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
   localparam logic [1:0] KIND_CHUNK_END = 2'd1;
   localparam logic [1:0] KIND_FINAL_END = 2'd2;
   localparam logic [1:0] KIND_ERROR     = 2'd3;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_EMPTY_SIZE = 3'd1;
   localparam logic [2:0] ERR_NON_HEX    = 3'd2;
   localparam logic [2:0] ERR_TOO_LARGE  = 3'd3;
   localparam logic [2:0] ERR_EXT_LONG   = 3'd4;
   localparam logic [2:0] ERR_LINE_LONG  = 3'd5;
   localparam logic [2:0] ERR_BAD_CRLF   = 3'd6;

   // control register indexes
   localparam logic [1:0] CSR_MAX_CHUNK_SIZE = 2'd0;
   localparam logic [1:0] CSR_MAX_EXT_LEN    = 2'd1;
   localparam logic [1:0] CSR_MAX_LINE_LEN   = 2'd2;

   localparam logic [15:0] MAX_CHUNK_SIZE_RST = 16'd65535;
   localparam logic [7:0]  MAX_EXT_LEN_RST    = 8'd255;
   localparam logic [8:0]  MAX_LINE_LEN_RST   = 9'd273;

   typedef struct packed {
      logic [15:0] max_chunk_size;
      logic [7:0]  max_ext_len;
      logic [8:0]  max_line_len;
   } cfg_type;

   // one classified stream byte, as held in the queue
   typedef struct packed {
      logic [7:0] data;
      logic       is_hex;
      logic [3:0] hex_val;
      logic       is_cr;
      logic       is_lf;
      logic       is_semi;
   } qitem_type;

   function automatic qitem_type classify(logic [7:0] b);
      qitem_type q;
      q.data    = b;
      q.is_cr   = (b == CH_CR);
      q.is_lf   = (b == CH_LF);
      q.is_semi = (b == CH_SEMI);
      q.is_hex  = 1'b1;
      q.hex_val = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         q.hex_val = b[3:0];
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         q.hex_val = b[3:0] + 4'd9;
      end else begin
         q.is_hex = 1'b0;
      end
      return q;
   endfunction

endpackage

// ===== sv/hcd_front.sv =====
// hcd_front: accepts stream bytes, classifies them and queues them for the parser.
// Depends on hcd_pkg.

module hcd_front #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   output logic                q_valid,
   output hcd_pkg::qitem_type  q_item,
   input  logic                q_pop
);
   import hcd_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

   qitem_type       entries_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push;
   logic            pop;

   assign req_stall = (count_ff == FullCnt);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= classify(req_in_byte);
      end
   end

endmodule

// ===== sv/hcd_back.sv =====
// hcd_back: chunk parser state machine and result register.
// Depends on hcd_pkg; takes classified bytes from hcd_front.

module hcd_back (
   input  logic                clock,
   input  logic                reset,
   input  hcd_pkg::cfg_type    cfg,
   input  logic                q_valid,
   input  hcd_pkg::qitem_type  q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_out_byte,
   output logic [15:0]         rsp_chunk_len,
   output logic [16:0]         rsp_consumed,
   output logic [2:0]          rsp_error_code
);
   import hcd_pkg::*;

   typedef enum logic [6:0] {
      PH_LINE    = 7'b0000001,
      PH_DATA    = 7'b0000010,
      PH_DATA_CR = 7'b0000100,
      PH_DATA_LF = 7'b0001000,
      PH_FIN_CR  = 7'b0010000,
      PH_FIN_LF  = 7'b0100000,
      PH_ERROR   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [8:0]  line_cnt;
      logic [8:0]  ext_cnt;
      logic        in_ext;
      logic [2:0]  lat_err;
      logic        has_digit;
      logic [15:0] size;
      logic        too_large;
   } line_st_type;

   typedef struct packed {
      line_st_type st;
      logic [2:0]  err;
   } line_res_type;

   localparam line_st_type LINE_CLEAR = '0;

   // one size-line byte; err is an immediate fault
   function automatic line_res_type line_byte(line_st_type s, qitem_type c,
                                              logic [15:0] max_size,
                                              logic [8:0] max_line);
      line_res_type r;
      logic [19:0]  v;
      r.st  = s;
      r.err = ERR_NONE;
      v     = {s.size, c.hex_val};
      if (s.line_cnt >= max_line) begin
         r.err = ERR_LINE_LONG;
      end else begin
         r.st.line_cnt = s.line_cnt + 9'd1;
         if (s.in_ext) begin
            if (s.ext_cnt != 9'h1FF) begin
               r.st.ext_cnt = s.ext_cnt + 9'd1;
            end
         end else if (c.is_semi) begin
            r.st.in_ext = 1'b1;
         end else if (!c.is_hex) begin
            if (s.lat_err == ERR_NONE) begin
               r.st.lat_err = ERR_NON_HEX;
            end
         end else begin
            r.st.has_digit = 1'b1;
            if (v > {4'd0, max_size}) begin
               r.st.too_large = 1'b1;
               r.st.size      = 16'hFFFF;
               if (s.lat_err == ERR_NONE) begin
                  r.st.lat_err = ERR_TOO_LARGE;
               end
            end else begin
               r.st.size = v[15:0];
            end
         end
      end
      return r;
   endfunction

   phase_type   phase_ff, phase_in;
   line_st_type line_ff, line_in;
   logic        pend_cr_ff, pend_cr_in;
   logic [15:0] left_ff, left_in;
   logic [16:0] total_ff, total_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic [15:0] len_ff, len_in;
   logic [16:0] cons_ff, cons_in;
   logic [2:0]  err_ff, err_in;

   logic         res_valid;
   logic [2:0]   verdict;
   logic [2:0]   fail_code;
   logic         fail;
   logic [16:0]  tot;
   logic [15:0]  left_dec;
   line_res_type r1, r2;

   // a new byte is parsed only when the result register is free or draining
   assign q_pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      verdict = ERR_NONE;
      if (line_ff.line_cnt == 9'd0) begin
         verdict = ERR_EMPTY_SIZE;
      end else if (line_ff.in_ext && (line_ff.ext_cnt > {1'b0, cfg.max_ext_len})) begin
         verdict = ERR_EXT_LONG;
      end else if (!line_ff.has_digit) begin
         verdict = ERR_EMPTY_SIZE;
      end else if (line_ff.lat_err != ERR_NONE) begin
         verdict = line_ff.lat_err;
      end else if (line_ff.too_large) begin
         verdict = ERR_TOO_LARGE;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      line_in    = line_ff;
      pend_cr_in = pend_cr_ff;
      left_in    = left_ff;
      total_in   = total_ff;
      res_valid  = 1'b0;
      kind_in    = KIND_PAYLOAD;
      byte_in    = 8'd0;
      len_in     = 16'd0;
      cons_in    = 17'd0;
      err_in     = ERR_NONE;
      fail       = 1'b0;
      fail_code  = ERR_NONE;
      tot        = (total_ff == 17'h1FFFF) ? total_ff : total_ff + 17'd1;
      left_dec   = (left_ff != 16'd0) ? left_ff - 16'd1 : left_ff;
      r1.st      = line_ff;
      r1.err     = ERR_NONE;
      r2         = line_byte(line_ff, q_item, cfg.max_chunk_size, cfg.max_line_len);

      if (q_pop) begin
         total_in = tot;
         unique case (phase_ff)
            PH_LINE: begin
               if (q_item.is_lf && pend_cr_ff) begin
                  pend_cr_in = 1'b0;
                  if (verdict != ERR_NONE) begin
                     fail      = 1'b1;
                     fail_code = verdict;
                  end else if (line_ff.size == 16'd0) begin
                     phase_in = PH_FIN_CR;
                  end else begin
                     left_in  = line_ff.size;
                     phase_in = PH_DATA;
                  end
               end else begin
                  // an unresolved CR that was not followed by LF is a plain line byte
                  if (pend_cr_ff) begin
                     r1 = line_byte(line_ff, classify(CH_CR), cfg.max_chunk_size,
                                    cfg.max_line_len);
                  end
                  r2 = line_byte(r1.st, q_item, cfg.max_chunk_size, cfg.max_line_len);
                  if (r1.err != ERR_NONE) begin
                     fail      = 1'b1;
                     fail_code = r1.err;
                  end else if (q_item.is_cr) begin
                     line_in    = r1.st;
                     pend_cr_in = 1'b1;
                  end else if (r2.err != ERR_NONE) begin
                     fail      = 1'b1;
                     fail_code = r2.err;
                  end else begin
                     line_in    = r2.st;
                     pend_cr_in = 1'b0;
                  end
               end
            end
            PH_DATA: begin
               left_in = left_dec;
               if (left_dec == 16'd0) begin
                  phase_in = PH_DATA_CR;
               end
               res_valid = 1'b1;
               kind_in   = KIND_PAYLOAD;
               byte_in   = q_item.data;
            end
            PH_DATA_CR: begin
               if (!q_item.is_cr) begin
                  fail      = 1'b1;
                  fail_code = ERR_BAD_CRLF;
               end else begin
                  phase_in = PH_DATA_LF;
               end
            end
            PH_FIN_CR: begin
               if (!q_item.is_cr) begin
                  fail      = 1'b1;
                  fail_code = ERR_BAD_CRLF;
               end else begin
                  phase_in = PH_FIN_LF;
               end
            end
            PH_DATA_LF, PH_FIN_LF: begin
               if (!q_item.is_lf) begin
                  fail      = 1'b1;
                  fail_code = ERR_BAD_CRLF;
               end else begin
                  res_valid  = 1'b1;
                  kind_in    = (phase_ff == PH_DATA_LF) ? KIND_CHUNK_END : KIND_FINAL_END;
                  len_in     = (phase_ff == PH_DATA_LF) ? line_ff.size : 16'd0;
                  cons_in    = tot;
                  phase_in   = PH_LINE;
                  line_in    = LINE_CLEAR;
                  pend_cr_in = 1'b0;
                  left_in    = 16'd0;
                  total_in   = 17'd0;
               end
            end
            PH_ERROR: begin
               total_in = total_ff;
            end
            default: begin
               phase_in = PH_ERROR;
            end
         endcase

         if (fail) begin
            phase_in          = PH_ERROR;
            line_in.lat_err   = fail_code;
            res_valid         = 1'b1;
            kind_in           = KIND_ERROR;
            err_in            = fail_code;
         end
      end

      if (q_pop) begin
         rsp_valid_in = res_valid;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LINE;
         line_ff      <= LINE_CLEAR;
         pend_cr_ff   <= 1'b0;
         left_ff      <= 16'd0;
         total_ff     <= 17'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         line_ff      <= line_in;
         pend_cr_ff   <= pend_cr_in;
         left_ff      <= left_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && res_valid) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         len_ff  <= len_in;
         cons_ff <= cons_in;
         err_ff  <= err_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_chunk_len  = len_ff;
   assign rsp_consumed   = cons_ff;
   assign rsp_error_code = err_ff;

endmodule

// ===== sv/http_chunked_deframer.sv =====
// http_chunked_deframer: top level of the HTTP chunked transfer deframer.
// Holds the control registers; instantiates hcd_front and hcd_back; uses hcd_pkg.
//
// Usage:
//   req_*  : one stream byte per transfer (req_valid / req_stall).
//   rsp_*  : zero or one result per byte: payload byte, chunk end, final
//            chunk end or error (rsp_valid / rsp_stall).
//   csr_*  : register writes (index 0 max chunk size, 1 max extension
//            length, 2 max size-line length); csr_ready is always high.
// Throughput is one byte per cycle while rsp_stall is low. A byte accepted
// is held in the input queue register, and its result then goes to the
// parser's result register.
// The parser handles one queued byte per cycle whenever the result register
// is empty or being taken.
// Reset clears the queue, returns the parser to the size line and loads the
// register defaults (65535, 255, 273). After an error the block drops all
// further bytes without results until reset.
// While rsp_stall is high the result holds, the queue fills and req_stall
// rises once QUEUE_DEPTH bytes wait.

module http_chunked_deframer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [15:0] rsp_chunk_len,
   output logic [16:0] rsp_consumed,
   output logic [2:0]  rsp_error_code,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import hcd_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      q_valid;
   qitem_type q_item;
   logic      q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_CHUNK_SIZE: cfg_in.max_chunk_size = csr_wdata;
            CSR_MAX_EXT_LEN:    cfg_in.max_ext_len    = csr_wdata[7:0];
            CSR_MAX_LINE_LEN:   cfg_in.max_line_len   = csr_wdata[8:0];
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_chunk_size <= MAX_CHUNK_SIZE_RST;
         cfg_ff.max_ext_len    <= MAX_EXT_LEN_RST;
         cfg_ff.max_line_len   <= MAX_LINE_LEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hcd_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   hcd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_chunk_len  (rsp_chunk_len),
      .rsp_consumed   (rsp_consumed),
      .rsp_error_code (rsp_error_code)
   );

endmodule
